@@ sv/rvex_pkg.sv @@
// rvex_pkg: shared types and constants for the rv32im execute unit
// depends on nothing; imported by every module of the block

package rvex_pkg;

  localparam logic [6:0] OpLui    = 7'h37;
  localparam logic [6:0] OpAuipc  = 7'h17;
  localparam logic [6:0] OpJal    = 7'h6f;
  localparam logic [6:0] OpJalr   = 7'h67;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpReg    = 7'h33;
  localparam logic [6:0] OpFence  = 7'h0f;
  localparam logic [6:0] OpSystem = 7'h73;

  localparam logic [31:0] InsEcall  = 32'h0000_0073;
  localparam logic [31:0] InsEbreak = 32'h0010_0073;

  localparam logic [1:0] ExcNone    = 2'd0;
  localparam logic [1:0] ExcIllegal = 2'd1;
  localparam logic [1:0] ExcEcall   = 2'd2;
  localparam logic [1:0] ExcEbreak  = 2'd3;

  localparam logic [1:0] MemNone  = 2'd0;
  localparam logic [1:0] MemLoad  = 2'd1;
  localparam logic [1:0] MemStore = 2'd2;

  // execution class chosen by the front end
  typedef enum logic [1:0] {
    ClsAlu = 2'd0,
    ClsMul = 2'd1,
    ClsDiv = 2'd2
  } cls_e;

  // classified item handed from front to back
  typedef struct packed {
    cls_e        cls;
    logic [2:0]  f3;
    logic        alt;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [4:0]  rd_index;
    logic        rd_write;
    logic [31:0] rd_value;   // final value for non alu/mul/div classes
    logic        use_alu;
    logic [31:0] next_pc;
    logic [1:0]  mem_kind;
    logic [31:0] mem_addr;
    logic [1:0]  mem_size;
    logic        mem_unsigned;
    logic [31:0] store_data;
    logic [1:0]  exception;
  } uop_t;

endpackage

@@ sv/rvex_front.sv @@
// rvex_front: decodes one instruction beat into a classified uop
// depends on rvex_pkg

module rvex_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [31:0]        instruction_i,
  input  logic [31:0]        pc_i,
  input  logic [31:0]        rs1_value_i,
  input  logic [31:0]        rs2_value_i,
  output logic               valid_o,
  input  logic               ready_i,
  output rvex_pkg::uop_t     uop_o
);
  import rvex_pkg::*;

  logic [6:0]  opc;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j, seq, a, b;
  logic        taken;
  uop_t        u;
  uop_t        uop_q;
  logic        valid_q;

  assign opc = instruction_i[6:0];
  assign rd  = instruction_i[11:7];
  assign f3  = instruction_i[14:12];
  assign f7  = instruction_i[31:25];
  assign a   = rs1_value_i;
  assign b   = rs2_value_i;

  // immediates
  assign imm_i = {{20{instruction_i[31]}}, instruction_i[31:20]};
  assign imm_s = {{20{instruction_i[31]}}, instruction_i[31:25], instruction_i[11:7]};
  assign imm_b = {{19{instruction_i[31]}}, instruction_i[31], instruction_i[7],
                  instruction_i[30:25], instruction_i[11:8], 1'b0};
  assign imm_u = {instruction_i[31:12], 12'h000};
  assign imm_j = {{11{instruction_i[31]}}, instruction_i[31], instruction_i[19:12],
                  instruction_i[20], instruction_i[30:21], 1'b0};
  assign seq   = pc_i + 32'd4;

  // branch condition
  always_comb begin
    case (f3)
      3'd0:    taken = (a == b);
      3'd1:    taken = (a != b);
      3'd4:    taken = ($signed(a) < $signed(b));
      3'd5:    taken = !($signed(a) < $signed(b));
      3'd6:    taken = (a < b);
      3'd7:    taken = (a >= b);
      default: taken = 1'b0;
    endcase
  end

  // decode
  always_comb begin
    u = '0;
    u.cls = ClsAlu;
    u.f3 = f3;
    u.op_a = a;
    u.op_b = b;
    u.next_pc = seq;
    case (opc)
      OpLui: begin
        u.rd_index = rd; u.rd_write = 1'b1; u.rd_value = imm_u;
      end
      OpAuipc: begin
        u.rd_index = rd; u.rd_write = 1'b1; u.rd_value = pc_i + imm_u;
      end
      OpJal: begin
        u.rd_index = rd; u.rd_write = 1'b1; u.rd_value = seq; u.next_pc = pc_i + imm_j;
      end
      OpJalr: begin
        if (f3 != 3'd0) begin
          u.exception = ExcIllegal;
        end else begin
          u.rd_index = rd; u.rd_write = 1'b1; u.rd_value = seq;
          u.next_pc = (a + imm_i) & ~32'd1;
        end
      end
      OpBranch: begin
        if (f3 == 3'd2 || f3 == 3'd3) u.exception = ExcIllegal;
        else if (taken) u.next_pc = pc_i + imm_b;
      end
      OpLoad: begin
        if (f3 == 3'd3 || f3 >= 3'd6) begin
          u.exception = ExcIllegal;
        end else begin
          u.rd_index = rd; u.mem_kind = MemLoad; u.mem_addr = a + imm_i;
          u.mem_size = f3[1:0]; u.mem_unsigned = f3[2];
        end
      end
      OpStore: begin
        if (f3 > 3'd2) begin
          u.exception = ExcIllegal;
        end else begin
          u.mem_kind = MemStore; u.mem_addr = a + imm_s;
          u.mem_size = f3[1:0]; u.store_data = b;
        end
      end
      OpImm: begin
        if ((f3 == 3'd1 && f7 != 7'd0) ||
            (f3 == 3'd5 && f7 != 7'd0 && f7 != 7'h20)) begin
          u.exception = ExcIllegal;
        end else begin
          u.rd_index = rd; u.rd_write = 1'b1; u.use_alu = 1'b1;
          u.op_b = imm_i; u.alt = (f3 == 3'd5) && (f7 == 7'h20);
        end
      end
      OpReg: begin
        if (f7 == 7'd1) begin
          u.rd_index = rd; u.rd_write = 1'b1; u.use_alu = 1'b1;
          u.cls = f3[2] ? ClsDiv : ClsMul;
        end else if (f7 == 7'd0 || (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5))) begin
          u.rd_index = rd; u.rd_write = 1'b1; u.use_alu = 1'b1;
          u.alt = (f7 == 7'h20);
        end else begin
          u.exception = ExcIllegal;
        end
      end
      OpFence: begin
        if (f3 > 3'd1) u.exception = ExcIllegal;
      end
      OpSystem: begin
        if (instruction_i == InsEcall) u.exception = ExcEcall;
        else if (instruction_i == InsEbreak) u.exception = ExcEbreak;
        else u.exception = ExcIllegal;
      end
      default: u.exception = ExcIllegal;
    endcase
    if (u.exception != ExcNone) begin
      u.next_pc = seq; u.rd_index = '0; u.rd_write = 1'b0; u.use_alu = 1'b0;
      u.mem_kind = MemNone; u.mem_addr = '0; u.mem_size = '0;
      u.mem_unsigned = 1'b0; u.store_data = '0; u.cls = ClsAlu;
    end
    if (u.rd_index == 5'd0) begin
      u.rd_write = 1'b0; u.use_alu = 1'b0; u.cls = ClsAlu;
    end
    if (!u.rd_write) u.rd_value = '0;
  end

  // output register stage
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign uop_o   = uop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      uop_q <= u;
    end
  end

endmodule

@@ sv/rvex_queue.sv @@
// rvex_queue: small fifo of classified uops between front and back
// depends on rvex_pkg

module rvex_queue #(
  parameter int Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  rvex_pkg::uop_t uop_i,
  output logic           valid_o,
  input  logic           ready_i,
  output rvex_pkg::uop_t uop_o
);
  import rvex_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  uop_t              mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;
  logic              push, pop;

  assign ready_o = (cnt_q != Depth[PtrW:0]);
  assign valid_o = (cnt_q != '0);
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign uop_o   = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + {{PtrW{1'b0}}, push} - {{PtrW{1'b0}}, pop};
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= uop_i;
  end

endmodule

@@ sv/rvex_back.sv @@
// rvex_back: executes uops through a two-stage alu/mul/div pipeline
// depends on rvex_pkg

module rvex_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  rvex_pkg::uop_t uop_i,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [4:0]     rd_index_o,
  output logic           rd_write_o,
  output logic [31:0]    rd_value_o,
  output logic [31:0]    next_pc_o,
  output logic [1:0]     mem_kind_o,
  output logic [31:0]    mem_addr_o,
  output logic [1:0]     mem_size_o,
  output logic           mem_unsigned_o,
  output logic [31:0]    store_data_o,
  output logic [1:0]     exception_o
);
  import rvex_pkg::*;

  localparam int DivSteps = 32;
  localparam int StepW = $clog2(DivSteps + 1);

  // divider state machine, one quotient bit per cycle
  typedef enum logic [1:0] {
    DivIdle = 2'd0,
    DivRun  = 2'd1,
    DivDone = 2'd2
  } div_state_e;

  uop_t        s1_q, s2_q, s2_d;
  logic        s1_valid_q, s2_valid_q;
  logic        s1_ready, s2_ready;
  logic        s1_fire;
  logic [63:0] prod_q;
  logic [31:0] alu_q;
  logic [32:0] ma, mb;

  div_state_e      div_state_q;
  logic [StepW-1:0] div_cnt_q;
  logic [31:0]     div_quo_q, div_rem_q, div_den_q;
  logic [31:0]     div_res;
  logic [33:0]     trial;
  logic [32:0]     rem_sh;
  logic            neg_q, neg_r;
  logic [31:0]     mag_a, mag_b, q_fix, r_fix, res1;
  logic            s1_div, div_ok;

  logic [31:0]     alu_d;
  logic [4:0]      sh;

  // combinational alu on the incoming uop
  assign sh = uop_i.op_b[4:0];
  always_comb begin
    case (uop_i.f3)
      3'd0: alu_d = uop_i.alt ? uop_i.op_a - uop_i.op_b : uop_i.op_a + uop_i.op_b;
      3'd1: alu_d = uop_i.op_a << sh;
      3'd2: alu_d = {31'd0, $signed(uop_i.op_a) < $signed(uop_i.op_b)};
      3'd3: alu_d = {31'd0, uop_i.op_a < uop_i.op_b};
      3'd4: alu_d = uop_i.op_a ^ uop_i.op_b;
      3'd5: alu_d = uop_i.alt ? 32'($signed(uop_i.op_a) >>> sh) : uop_i.op_a >> sh;
      3'd6: alu_d = uop_i.op_a | uop_i.op_b;
      default: alu_d = uop_i.op_a & uop_i.op_b;
    endcase
  end

  // multiplier operand extension
  always_comb begin
    ma = {1'b0, uop_i.op_a};
    mb = {1'b0, uop_i.op_b};
    case (uop_i.f3[1:0])
      2'd1: begin ma = {uop_i.op_a[31], uop_i.op_a}; mb = {uop_i.op_b[31], uop_i.op_b}; end
      2'd2: ma = {uop_i.op_a[31], uop_i.op_a};
      default: ;
    endcase
  end

  assign s1_ready = !s1_valid_q || (s2_ready && div_ok);
  assign ready_o  = s1_ready;
  assign s1_fire  = valid_i && s1_ready;
  assign s1_div   = s1_valid_q && (s1_q.cls == ClsDiv);
  assign div_ok   = !s1_div || (div_state_q == DivDone);
  assign s2_ready = !s2_valid_q || ready_i;

  // stage 1: alu result and multiply product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s1_q   <= uop_i;
      alu_q  <= alu_d;
      prod_q <= 64'($signed(ma) * $signed(mb));
    end
  end

  // divider over stage 1 operands
  assign mag_a  = s1_q.op_a[31] && !s1_q.f3[0] ? 32'd0 - s1_q.op_a : s1_q.op_a;
  assign mag_b  = s1_q.op_b[31] && !s1_q.f3[0] ? 32'd0 - s1_q.op_b : s1_q.op_b;
  assign rem_sh = {div_rem_q, div_quo_q[31]};
  assign trial  = {1'b0, rem_sh} - {2'b00, div_den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_state_q <= DivIdle;
      div_cnt_q   <= '0;
    end else begin
      case (div_state_q)
        DivIdle: begin
          if (s1_div) begin
            div_state_q <= DivRun;
            div_cnt_q   <= StepW'(DivSteps);
          end
        end
        DivRun: begin
          div_cnt_q <= div_cnt_q - 1'b1;
          if (div_cnt_q == StepW'(1)) div_state_q <= DivDone;
        end
        DivDone: begin
          if (s2_ready) div_state_q <= DivIdle;
        end
        default: div_state_q <= DivIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_state_q == DivIdle && s1_div) begin
      div_quo_q <= mag_a;
      div_rem_q <= '0;
      div_den_q <= mag_b;
      neg_q     <= !s1_q.f3[0] && (s1_q.op_a[31] ^ s1_q.op_b[31]);
      neg_r     <= !s1_q.f3[0] && s1_q.op_a[31];
    end else if (div_state_q == DivRun) begin
      if (!trial[33]) begin
        div_rem_q <= trial[31:0];
        div_quo_q <= {div_quo_q[30:0], 1'b1};
      end else begin
        div_rem_q <= rem_sh[31:0];
        div_quo_q <= {div_quo_q[30:0], 1'b0};
      end
    end
  end

  // sign fixup and divide-by-zero rules
  assign q_fix = neg_q ? 32'd0 - div_quo_q : div_quo_q;
  assign r_fix = neg_r ? 32'd0 - div_rem_q : div_rem_q;
  always_comb begin
    if (s1_q.op_b == 32'd0) div_res = s1_q.f3[1] ? s1_q.op_a : 32'hffff_ffff;
    else                    div_res = s1_q.f3[1] ? r_fix : q_fix;
  end

  // result select
  always_comb begin
    res1 = s1_q.rd_value;
    if (s1_q.use_alu) begin
      case (s1_q.cls)
        ClsMul:  res1 = (s1_q.f3[1:0] == 2'd0) ? prod_q[31:0] : prod_q[63:32];
        ClsDiv:  res1 = div_res;
        default: res1 = alu_q;
      endcase
    end
  end

  // next output beat
  always_comb begin
    s2_d          = s1_q;
    s2_d.rd_value = res1;
  end

  // stage 2: output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q && div_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q && div_ok) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o        = s2_valid_q;
  assign rd_index_o     = s2_q.rd_index;
  assign rd_write_o     = s2_q.rd_write;
  assign rd_value_o     = s2_q.rd_value;
  assign next_pc_o      = s2_q.next_pc;
  assign mem_kind_o     = s2_q.mem_kind;
  assign mem_addr_o     = s2_q.mem_addr;
  assign mem_size_o     = s2_q.mem_size;
  assign mem_unsigned_o = s2_q.mem_unsigned;
  assign store_data_o   = s2_q.store_data;
  assign exception_o    = s2_q.exception;

endmodule

@@ sv/rv32im_execute_unit.sv @@
// rv32im_execute_unit: one instruction beat in, one result beat out. The front end decodes
// and registers each instruction, a small queue decouples it from the back end, which
// runs alu and multiply in a two-stage pipeline at one instruction per cycle while the output
// is not stalled. Divide and remainder iterate one quotient bit per cycle and hold the back end
// until the result is done; others pass the front register, the queue and both back stages.
// depends on rvex_pkg, rvex_front, rvex_queue, rvex_back

module rv32im_execute_unit #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instruction_i,
  input  logic [31:0] pc_i,
  input  logic [31:0] rs1_value_i,
  input  logic [31:0] rs2_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  rd_index_o,
  output logic        rd_write_o,
  output logic [31:0] rd_value_o,
  output logic [31:0] next_pc_o,
  output logic [1:0]  mem_kind_o,
  output logic [31:0] mem_addr_o,
  output logic [1:0]  mem_size_o,
  output logic        mem_unsigned_o,
  output logic [31:0] store_data_o,
  output logic [1:0]  exception_o
);
  import rvex_pkg::*;

  uop_t f_uop, q_uop;
  logic f_valid, f_ready, q_valid, q_ready;

  rvex_front u_front (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .ready_o(in_ready_o),
    .instruction_i, .pc_i, .rs1_value_i, .rs2_value_i,
    .valid_o(f_valid), .ready_i(f_ready), .uop_o(f_uop)
  );

  rvex_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .valid_i(f_valid), .ready_o(f_ready), .uop_i(f_uop),
    .valid_o(q_valid), .ready_i(q_ready), .uop_o(q_uop)
  );

  rvex_back u_back (
    .clk_i, .rst_ni,
    .valid_i(q_valid), .ready_o(q_ready), .uop_i(q_uop),
    .valid_o(out_valid_o), .ready_i(out_ready_i),
    .rd_index_o, .rd_write_o, .rd_value_o, .next_pc_o, .mem_kind_o,
    .mem_addr_o, .mem_size_o, .mem_unsigned_o, .store_data_o, .exception_o
  );

endmodule

@@ sv/rvex_checker.sv @@
// rvex_checker: port-level assertions for rv32im_execute_unit
// depends on rvex_pkg; bound to the top level

module rvex_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [4:0]  rd_index_o,
  input logic        rd_write_o,
  input logic [31:0] rd_value_o,
  input logic [1:0]  mem_kind_o,
  input logic [31:0] store_data_o,
  input logic [1:0]  exception_o
);
  import rvex_pkg::*;

  // a stalled result beat stays valid with a stable rd_value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rd_value_o))
    else $error("result beat changed while stalled");

  // x0 is never written
  a_x0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rd_index_o == 5'd0 |-> !rd_write_o)
    else $error("write to x0");

  // exceptions suppress memory and writes
  a_exc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exception_o != ExcNone |-> mem_kind_o == MemNone && !rd_write_o)
    else $error("exception with side effect");

  // unused value is zero
  a_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rd_write_o |-> rd_value_o == 32'd0)
    else $error("rd_value nonzero without write");

  // store data only for stores
  a_sd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mem_kind_o != MemStore |-> store_data_o == 32'd0)
    else $error("store data without store");

endmodule

bind rv32im_execute_unit rvex_checker u_rvex_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .rd_index_o, .rd_write_o,
  .rd_value_o, .mem_kind_o, .store_data_o, .exception_o
);
